// ----- rtl/core/lrm_pkg.sv -----
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared constants and types of the midpoint line rasteriser.
// ----------------------------------------------------------------------------
package lrm_pkg;

    localparam int DEFAULT_COORD_BITS = 12;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam int ADDR_BITS   = 32;
    localparam int COLOR_BITS  = 32;
    localparam int STRIDE_BITS = 16;
    localparam int BPP_BITS    = 4;

    localparam logic [BPP_BITS-1:0] BPP_RESET = 4'd4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_BASE      = 2'd0,
        REG_ROW_STRIDE      = 2'd1,
        REG_BYTES_PER_PIXEL = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } opcode_t;

endpackage

// ----- rtl/core/lrm_if.sv -----
// ----------------------------------------------------------------------------
// lrm_cmd_if / lrm_pix_if
// Valid/ready channels of the line rasteriser: command requests in, pixels out.
// ----------------------------------------------------------------------------
interface lrm_cmd_if #(
    parameter int COORD_BITS = lrm_pkg::DEFAULT_COORD_BITS
);
    import lrm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, color,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, color,
        output ready
    );
endinterface

interface lrm_pix_if #(
    parameter int COORD_BITS = lrm_pkg::DEFAULT_COORD_BITS
);
    import lrm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
        output ready
    );
endinterface

// ----- rtl/core/line_rasterizer_midpoint.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_midpoint
// Midpoint line engine: start and next-pixel requests in, one pixel out each.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : valid/ready request channel. Opcode start loads two endpoints and a
//          colour and yields the first pixel; opcode next yields the following
//          pixel. A next with no line in progress yields pixel_valid = 0.
//   pix  : valid/ready result channel, exactly one result per request, with
//          last set on the final pixel of a line.
//   cfg  : plain write port (cfg_we, cfg_index, cfg_data); write only while idle.
// Timing:
//   One request per cycle sustained while pix.ready holds. Stages in order:
//   line stepping, address multiplies, address sum. The decision-term
//   update and the two address products set the per-stage logic depth.
// Reset:
//   rst_n clears all line state and pipeline valids; config returns to base 0,
//   stride 0, 4 bytes per pixel.
// Stall:
//   A stalled pix holds its result; the stages behind it keep filling until
//   full, then cmd.ready drops.
// ----------------------------------------------------------------------------
module line_rasterizer_midpoint #(
    parameter int COORD_BITS = lrm_pkg::DEFAULT_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lrm_cmd_if.sink                           cmd,
    lrm_pix_if.source                         pix,
    input  logic                              cfg_we,
    input  logic [lrm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lrm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lrm_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = COORD_BITS + 3;
    localparam int PYW = COORD_BITS + STRIDE_BITS;
    localparam int PXW = COORD_BITS + BPP_BITS;

    // configuration
    logic [ADDR_BITS-1:0]   frame_base_reg;
    logic [STRIDE_BITS-1:0] row_stride_reg;
    logic [BPP_BITS-1:0]    bpp_reg;

    // line state
    logic                 active_reg,     active_next;
    logic [CW-1:0]        major_pos_reg,  major_pos_next;
    logic [CW-1:0]        major_end_reg,  major_end_next;
    logic [CW-1:0]        minor_pos_reg,  minor_pos_next;
    logic [CW-1:0]        major_delta_reg, major_delta_next;
    logic [CW-1:0]        minor_delta_reg, minor_delta_next;
    logic signed [DW-1:0] decision_reg,   decision_next;
    logic                 steep_reg,      steep_next;
    logic                 minor_down_reg, minor_down_next;
    logic [COLOR_BITS-1:0] line_color_reg, line_color_next;

    // pipeline
    logic                  s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic                  s1_pv_reg, s2_pv_reg, out_pv_reg;
    logic [CW-1:0]         s1_x_reg, s2_x_reg, out_x_reg;
    logic [CW-1:0]         s1_y_reg, s2_y_reg, out_y_reg;
    logic [COLOR_BITS-1:0] s1_color_reg, s2_color_reg, out_color_reg;
    logic                  s1_last_reg, s2_last_reg, out_last_reg;
    logic [PYW-1:0]        s2_prod_y_reg;
    logic [PXW-1:0]        s2_prod_x_reg;
    logic [ADDR_BITS-1:0]  out_addr_reg;

    logic out_adv, s2_adv, s1_adv, in_fire, is_start;

    // setup
    logic [CW-1:0] dx, dy, s_maj0, s_min0, e_maj0, e_min0;
    logic [CW-1:0] set_maj_pos, set_maj_end, set_min_pos, set_maj_d, set_min_d;
    logic          set_steep, set_swap, set_down;
    logic signed [DW-1:0] set_dec;

    // current step
    logic [CW-1:0]        cur_maj_pos, cur_maj_end, cur_min_pos, cur_maj_d, cur_min_d;
    logic signed [DW-1:0] cur_dec, dec_diff2, dec_min2;
    logic                 cur_steep, cur_down, cur_fin, cur_pv, dec_pos;
    logic [COLOR_BITS-1:0] cur_color;

    assign out_adv   = !out_valid_reg || pix.ready;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign cmd.ready = s1_adv;
    assign in_fire   = cmd.valid && s1_adv;
    assign is_start  = (cmd.opcode == OP_START);

    always_comb
    begin
        dx        = (cmd.end_x > cmd.start_x) ? (cmd.end_x - cmd.start_x)
                                              : (cmd.start_x - cmd.end_x);
        dy        = (cmd.end_y > cmd.start_y) ? (cmd.end_y - cmd.start_y)
                                              : (cmd.start_y - cmd.end_y);
        set_steep = (dy > dx);
        s_maj0    = set_steep ? cmd.start_y : cmd.start_x;
        s_min0    = set_steep ? cmd.start_x : cmd.start_y;
        e_maj0    = set_steep ? cmd.end_y   : cmd.end_x;
        e_min0    = set_steep ? cmd.end_x   : cmd.end_y;
        set_maj_d = set_steep ? dy : dx;
        set_min_d = set_steep ? dx : dy;
        set_swap  = (e_maj0 < s_maj0);
        set_maj_pos = set_swap ? e_maj0 : s_maj0;
        set_maj_end = set_swap ? s_maj0 : e_maj0;
        set_min_pos = set_swap ? e_min0 : s_min0;
        set_down    = set_swap ? (e_min0 > s_min0) : (s_min0 > e_min0);
        set_dec     = $signed({2'b00, set_min_d, 1'b0}) - $signed({3'b000, set_maj_d});
    end

    always_comb
    begin
        if (is_start)
        begin
            cur_maj_pos = set_maj_pos;
            cur_maj_end = set_maj_end;
            cur_min_pos = set_min_pos;
            cur_maj_d   = set_maj_d;
            cur_min_d   = set_min_d;
            cur_dec     = set_dec;
            cur_steep   = set_steep;
            cur_down    = set_down;
            cur_color   = cmd.color;
            cur_pv      = 1'b1;
        end
        else
        begin
            cur_maj_pos = major_pos_reg;
            cur_maj_end = major_end_reg;
            cur_min_pos = minor_pos_reg;
            cur_maj_d   = major_delta_reg;
            cur_min_d   = minor_delta_reg;
            cur_dec     = decision_reg;
            cur_steep   = steep_reg;
            cur_down    = minor_down_reg;
            cur_color   = line_color_reg;
            cur_pv      = active_reg;
        end

        cur_fin   = (cur_maj_pos == cur_maj_end);
        dec_pos   = !cur_dec[DW-1] && (cur_dec != '0);
        dec_min2  = $signed({2'b00, cur_min_d, 1'b0});
        dec_diff2 = dec_min2 - $signed({2'b00, cur_maj_d, 1'b0});

        active_next      = active_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        decision_next    = decision_reg;
        steep_next       = steep_reg;
        minor_down_next  = minor_down_reg;
        line_color_next  = line_color_reg;

        if (in_fire && cur_pv)
        begin
            major_end_next   = cur_maj_end;
            major_delta_next = cur_maj_d;
            minor_delta_next = cur_min_d;
            steep_next       = cur_steep;
            minor_down_next  = cur_down;
            line_color_next  = cur_color;
            major_pos_next   = cur_maj_pos;
            minor_pos_next   = cur_min_pos;
            decision_next    = cur_dec;
            active_next      = !cur_fin;
            if (!cur_fin)
            begin
                major_pos_next = cur_maj_pos + 1'b1;
                if (dec_pos)
                begin
                    decision_next  = cur_dec + dec_diff2;
                    minor_pos_next = cur_down ? (cur_min_pos - 1'b1) : (cur_min_pos + 1'b1);
                end
                else
                begin
                    decision_next = cur_dec + dec_min2;
                end
            end
        end
    end

    // config and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= '0;
            row_stride_reg  <= '0;
            bpp_reg         <= BPP_RESET;
            active_reg      <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            decision_reg    <= '0;
            steep_reg       <= 1'b0;
            minor_down_reg  <= 1'b0;
            line_color_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_BASE:      frame_base_reg <= cfg_data[ADDR_BITS-1:0];
                    REG_ROW_STRIDE:      row_stride_reg <= cfg_data[STRIDE_BITS-1:0];
                    REG_BYTES_PER_PIXEL: bpp_reg        <= cfg_data[BPP_BITS-1:0];
                    default:             ;
                endcase
            end
            active_reg      <= active_next;
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            decision_reg    <= decision_next;
            steep_reg       <= steep_next;
            minor_down_reg  <= minor_down_next;
            line_color_reg  <= line_color_next;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= cmd.valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pv_reg    <= cur_pv;
            s1_x_reg     <= cur_pv ? (cur_steep ? cur_min_pos : cur_maj_pos) : '0;
            s1_y_reg     <= cur_pv ? (cur_steep ? cur_maj_pos : cur_min_pos) : '0;
            s1_color_reg <= cur_pv ? cur_color : '0;
            s1_last_reg  <= cur_pv && cur_fin;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_pv_reg     <= s1_pv_reg;
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_color_reg  <= s1_color_reg;
            s2_last_reg   <= s1_last_reg;
            s2_prod_y_reg <= PYW'(s1_y_reg) * PYW'(row_stride_reg);
            s2_prod_x_reg <= PXW'(s1_x_reg) * PXW'(bpp_reg);
        end
        if (out_adv && s2_valid_reg)
        begin
            out_pv_reg    <= s2_pv_reg;
            out_x_reg     <= s2_x_reg;
            out_y_reg     <= s2_y_reg;
            out_color_reg <= s2_color_reg;
            out_last_reg  <= s2_last_reg;
            out_addr_reg  <= s2_pv_reg ? (frame_base_reg + ADDR_BITS'(s2_prod_y_reg)
                                          + ADDR_BITS'(s2_prod_x_reg)) : '0;
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_valid   = out_pv_reg;
    assign pix.pixel_x       = out_x_reg;
    assign pix.pixel_y       = out_y_reg;
    assign pix.pixel_address = out_addr_reg;
    assign pix.pixel_color   = out_color_reg;
    assign pix.last          = out_last_reg;

endmodule
